[hw/rtl/list_mode_event_histogram_filtered_top_defines.svh]
// assertion macros used by the bound checker in lmeh_checker.sv
`ifndef LIST_MODE_EVENT_HISTOGRAM_FILTERED_TOP_DEFINES_SVH
`define LIST_MODE_EVENT_HISTOGRAM_FILTERED_TOP_DEFINES_SVH

// same-cycle implication, disabled during reset
`define LMEH_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, disabled during reset
`define LMEH_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

[hw/rtl/lmeh_pkg.sv]
package lmeh_pkg;

   // histogram geometry
   localparam int X_SIZE      = 16;
   localparam int Y_SIZE      = 16;
   localparam int CHANNELS    = 1024;
   localparam int COUNT_WIDTH = 32;
   localparam int HALF_CH     = CHANNELS / 2;
   localparam int BIN_TOTAL   = X_SIZE * Y_SIZE * CHANNELS;
   localparam int ADDR_W      = $clog2(BIN_TOTAL);
   localparam int CH_W        = $clog2(CHANNELS);
   localparam int CHK_W       = 17;
   localparam int OUT_W       = 32;

   // item modes
   localparam logic [1:0] MODE_COUNT = 2'd0;
   localparam logic [1:0] MODE_READ  = 2'd1;
   localparam logic [1:0] MODE_CLEAR = 2'd2;

   // result status codes
   localparam logic [2:0] STAT_COUNTED  = 3'd0;
   localparam logic [2:0] STAT_BAD_CH   = 3'd1;
   localparam logic [2:0] STAT_ZERO     = 3'd2;
   localparam logic [2:0] STAT_STOP_NOW = 3'd3;
   localparam logic [2:0] STAT_IGNORED  = 3'd4;
   localparam logic [2:0] STAT_READ     = 3'd5;
   localparam logic [2:0] STAT_CLEARED  = 3'd6;

   // controller to datapath commands
   typedef struct packed {
      logic load_item;
      logic lookup;
      logic update;
      logic load_rsp;
      logic sweep;
   } ctrl_cmd_type;

   // datapath to controller status
   typedef struct packed {
      logic is_clear;
      logic sweep_last;
   } dp_status_type;

endpackage

[hw/rtl/lmeh_ram.sv]
module lmeh_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // one write port, one registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[hw/rtl/lmeh_datapath.sv]
module lmeh_datapath (
   input  logic                  clock,
   input  logic                  reset,
   input  lmeh_pkg::ctrl_cmd_type cmd,
   output lmeh_pkg::dp_status_type stat,
   input  logic [1:0]            req_mode,
   input  logic [15:0]           req_channel,
   input  logic [7:0]            req_pos_x,
   input  logic [7:0]            req_pos_y,
   input  logic [3:0]            req_read_x,
   input  logic [3:0]            req_read_y,
   input  logic [9:0]            req_read_channel,
   output logic [31:0]           rsp_bin_count,
   output logic [2:0]            rsp_status,
   output logic                  rsp_halted
);

   // captured transaction fields
   logic [1:0]  mode_ff;
   logic [15:0] channel_ff;
   logic [7:0]  pos_x_ff;
   logic [7:0]  pos_y_ff;
   logic [3:0]  read_x_ff;
   logic [3:0]  read_y_ff;
   logic [9:0]  read_channel_ff;

   logic                          stop_ff, stop_in;
   logic [lmeh_pkg::ADDR_W-1:0]   sweep_addr_ff, sweep_addr_in;
   logic [lmeh_pkg::OUT_W-1:0]    res_count_ff, res_count_in;
   logic [2:0]                    res_status_ff;
   logic                          res_halted_ff;
   logic [lmeh_pkg::OUT_W-1:0]    rsp_count_ff;
   logic [2:0]                    rsp_status_ff;
   logic                          rsp_halted_ff;

   logic                          ch_ok, zero_pos, over_pos, read_ok;
   logic [lmeh_pkg::CH_W-1:0]     ch_lo, stored_ch;
   logic [7:0]                    x0, y0;
   logic [lmeh_pkg::ADDR_W-1:0]   count_addr, read_addr, item_addr;
   logic [2:0]                    status_now;
   logic                          halted_now;

   logic                             ram_we, ram_re;
   logic [lmeh_pkg::ADDR_W-1:0]      ram_waddr;
   logic [lmeh_pkg::COUNT_WIDTH-1:0] ram_wdata, ram_rdata;

   // event checks
   always_comb begin
      ch_ok    = {1'b0, channel_ff} < lmeh_pkg::CHK_W'(lmeh_pkg::CHANNELS);
      zero_pos = (pos_x_ff == 8'd0) || (pos_y_ff == 8'd0);
      over_pos = (pos_x_ff > 8'(lmeh_pkg::X_SIZE)) || (pos_y_ff > 8'(lmeh_pkg::Y_SIZE));
      read_ok  = ({4'd0, read_x_ff} < 8'(lmeh_pkg::X_SIZE))
              && ({4'd0, read_y_ff} < 8'(lmeh_pkg::Y_SIZE))
              && ({7'd0, read_channel_ff} < lmeh_pkg::CHK_W'(lmeh_pkg::CHANNELS));
   end

   // swap channel halves and form the bin addresses
   always_comb begin
      ch_lo = lmeh_pkg::CH_W'(channel_ff);
      if (ch_lo >= lmeh_pkg::CH_W'(lmeh_pkg::HALF_CH)) begin
         stored_ch = ch_lo - lmeh_pkg::CH_W'(lmeh_pkg::HALF_CH);
      end else begin
         stored_ch = ch_lo + lmeh_pkg::CH_W'(lmeh_pkg::HALF_CH);
      end
      x0 = pos_x_ff - 8'd1;
      y0 = pos_y_ff - 8'd1;
      count_addr = lmeh_pkg::ADDR_W'(
         (lmeh_pkg::ADDR_W'(x0) * lmeh_pkg::ADDR_W'(lmeh_pkg::Y_SIZE)
          + lmeh_pkg::ADDR_W'(y0)) * lmeh_pkg::ADDR_W'(lmeh_pkg::CHANNELS)
         + lmeh_pkg::ADDR_W'(stored_ch));
      read_addr = lmeh_pkg::ADDR_W'(
         (lmeh_pkg::ADDR_W'(read_x_ff) * lmeh_pkg::ADDR_W'(lmeh_pkg::Y_SIZE)
          + lmeh_pkg::ADDR_W'(read_y_ff)) * lmeh_pkg::ADDR_W'(lmeh_pkg::CHANNELS)
         + lmeh_pkg::ADDR_W'(read_channel_ff));
      item_addr = (mode_ff == lmeh_pkg::MODE_READ) ? read_addr : count_addr;
   end

   // status of the current transaction
   always_comb begin
      case (mode_ff)
         lmeh_pkg::MODE_COUNT: begin
            if (stop_ff) begin
               status_now = lmeh_pkg::STAT_IGNORED;
            end else if (!ch_ok) begin
               status_now = lmeh_pkg::STAT_BAD_CH;
            end else if (zero_pos) begin
               status_now = lmeh_pkg::STAT_ZERO;
            end else if (over_pos) begin
               status_now = lmeh_pkg::STAT_STOP_NOW;
            end else begin
               status_now = lmeh_pkg::STAT_COUNTED;
            end
         end
         lmeh_pkg::MODE_READ:  status_now = lmeh_pkg::STAT_READ;
         lmeh_pkg::MODE_CLEAR: status_now = lmeh_pkg::STAT_CLEARED;
         default:              status_now = lmeh_pkg::STAT_IGNORED;
      endcase
   end

   // stop flag and result values
   always_comb begin
      stop_in = stop_ff;
      if (cmd.update && status_now == lmeh_pkg::STAT_STOP_NOW) begin
         stop_in = 1'b1;
      end else if (cmd.update && status_now == lmeh_pkg::STAT_CLEARED) begin
         stop_in = 1'b0;
      end
      halted_now = stop_in;
      if (status_now == lmeh_pkg::STAT_READ && read_ok) begin
         res_count_in = lmeh_pkg::OUT_W'(ram_rdata);
      end else begin
         res_count_in = '0;
      end
   end

   // memory port control: sweep writes zero, update writes incremented count
   always_comb begin
      ram_re = cmd.lookup;
      ram_we = cmd.sweep || (cmd.update && status_now == lmeh_pkg::STAT_COUNTED);
      ram_waddr = cmd.sweep ? sweep_addr_ff : item_addr;
      ram_wdata = cmd.sweep ? '0 : ram_rdata + lmeh_pkg::COUNT_WIDTH'(1);
   end

   // clear sweep address
   always_comb begin
      stat.sweep_last = sweep_addr_ff == lmeh_pkg::ADDR_W'(lmeh_pkg::BIN_TOTAL - 1);
      stat.is_clear   = mode_ff == lmeh_pkg::MODE_CLEAR;
      sweep_addr_in   = sweep_addr_ff;
      if (cmd.sweep) begin
         sweep_addr_in = stat.sweep_last ? '0 : sweep_addr_ff + lmeh_pkg::ADDR_W'(1);
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         stop_ff       <= 1'b0;
         sweep_addr_ff <= '0;
      end else begin
         stop_ff       <= stop_in;
         sweep_addr_ff <= sweep_addr_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (cmd.load_item) begin
         mode_ff         <= req_mode;
         channel_ff      <= req_channel;
         pos_x_ff        <= req_pos_x;
         pos_y_ff        <= req_pos_y;
         read_x_ff       <= req_read_x;
         read_y_ff       <= req_read_y;
         read_channel_ff <= req_read_channel;
      end
      if (cmd.update) begin
         res_count_ff  <= res_count_in;
         res_status_ff <= status_now;
         res_halted_ff <= halted_now;
      end
      if (cmd.load_rsp) begin
         rsp_count_ff  <= res_count_ff;
         rsp_status_ff <= res_status_ff;
         rsp_halted_ff <= res_halted_ff;
      end
   end

   lmeh_ram #(
      .WIDTH (lmeh_pkg::COUNT_WIDTH),
      .DEPTH (lmeh_pkg::BIN_TOTAL)
   ) u_bins (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_en   (ram_re),
      .rd_addr (item_addr),
      .rd_data (ram_rdata)
   );

   assign rsp_bin_count = rsp_count_ff;
   assign rsp_status    = rsp_status_ff;
   assign rsp_halted    = rsp_halted_ff;

endmodule

[hw/rtl/lmeh_ctrl.sv]
module lmeh_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_stall,
   output logic                    rsp_valid,
   input  logic                    rsp_stall,
   output lmeh_pkg::ctrl_cmd_type  cmd,
   input  lmeh_pkg::dp_status_type stat
);

   localparam logic [2:0] S_SWEEP  = 3'd0;
   localparam logic [2:0] S_IDLE   = 3'd1;
   localparam logic [2:0] S_LOOKUP = 3'd2;
   localparam logic [2:0] S_UPDATE = 3'd3;
   localparam logic [2:0] S_DONE   = 3'd4;

   logic [2:0] state_ff, state_in;
   logic       rsp_valid_ff, rsp_valid_in;
   logic       out_free;

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign req_stall = state_ff != S_IDLE;
   assign rsp_valid = rsp_valid_ff;

   // sequencer
   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         S_SWEEP: begin
            cmd.sweep = 1'b1;
            if (stat.sweep_last) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (req_valid) begin
               cmd.load_item = 1'b1;
               state_in      = S_LOOKUP;
            end
         end
         S_LOOKUP: begin
            cmd.lookup = 1'b1;
            state_in   = S_UPDATE;
         end
         S_UPDATE: begin
            cmd.update = 1'b1;
            state_in   = S_DONE;
         end
         S_DONE: begin
            if (out_free) begin
               cmd.load_rsp = 1'b1;
               state_in     = stat.is_clear ? S_SWEEP : S_IDLE;
            end
         end
         default: begin
            state_in = S_SWEEP;
         end
      endcase
   end

   // output valid: set on load, dropped once taken
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.load_rsp) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_SWEEP;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

[hw/rtl/list_mode_event_histogram_filtered_top.sv]
// list-mode event histogram with a clearable bin cube
// req channel: one transaction per item; mode selects count event, read one bin
//   or clear all bins and the stop flag; req_stall high means the item is held
// rsp channel: exactly one transaction per item with bin_count, status, halted;
//   rsp_valid stays high and the payload holds while rsp_stall is high
// sequence: an accepted item passes the lookup and update states and loads the
//   output register from the done state as soon as that register is free
// items are handled one at a time by a read-modify-write through the single
//   registered-read bin memory; req_stall stays high until the result is loaded,
//   and the next item may be accepted while that result still waits to be taken
// clear: the result is offered first, then every bin is zeroed one per cycle
//   while req_stall is high
// reset: synchronous, active high; clears the stop flag and output valid, then
//   runs the same clearing pass before the first item is accepted
// a stalled receiver holds at most one finished result; the block waits
//   with the next result ready until that one is taken
module list_mode_event_histogram_filtered_top (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_mode,
   input  logic [15:0] req_channel,
   input  logic [7:0]  req_pos_x,
   input  logic [7:0]  req_pos_y,
   input  logic [3:0]  req_read_x,
   input  logic [3:0]  req_read_y,
   input  logic [9:0]  req_read_channel,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [31:0] rsp_bin_count,
   output logic [2:0]  rsp_status,
   output logic        rsp_halted
);

   lmeh_pkg::ctrl_cmd_type  cmd;
   lmeh_pkg::dp_status_type stat;

   // sequencing and handshake
   lmeh_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .cmd       (cmd),
      .stat      (stat)
   );

   // checks, bin memory and result registers
   lmeh_datapath u_datapath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .stat             (stat),
      .req_mode         (req_mode),
      .req_channel      (req_channel),
      .req_pos_x        (req_pos_x),
      .req_pos_y        (req_pos_y),
      .req_read_x       (req_read_x),
      .req_read_y       (req_read_y),
      .req_read_channel (req_read_channel),
      .rsp_bin_count    (rsp_bin_count),
      .rsp_status       (rsp_status),
      .rsp_halted       (rsp_halted)
   );

endmodule

[hw/rtl/lmeh_checker.sv]
`include "list_mode_event_histogram_filtered_top_defines.svh"

module lmeh_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_stall,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic [31:0] rsp_bin_count,
   input logic [2:0]  rsp_status,
   input logic        rsp_halted
);

   // a stalled result stays offered
   `LMEH_ASSERT_NEXT(a_rsp_hold, clock, reset,
      rsp_valid && rsp_stall, rsp_valid, "rsp dropped while stalled")

   // only a read returns a nonzero count
   `LMEH_ASSERT_IMPL(a_count_zero, clock, reset,
      rsp_valid && (rsp_status != lmeh_pkg::STAT_READ), rsp_bin_count == 32'd0,
      "nonzero count outside a read")

   // stop sets the flag; clear and a counted event leave it low
   `LMEH_ASSERT_IMPL(a_stop_flag, clock, reset,
      rsp_valid && (rsp_status == lmeh_pkg::STAT_STOP_NOW), rsp_halted,
      "stop without halted")

   `LMEH_ASSERT_IMPL(a_clear_flag, clock, reset,
      rsp_valid && ((rsp_status == lmeh_pkg::STAT_CLEARED)
                    || (rsp_status == lmeh_pkg::STAT_COUNTED)), !rsp_halted,
      "halted after clear or count")

   // clearing pass holds off input right after reset
   `LMEH_ASSERT_IMPL(a_reset_sweep, clock, reset,
      $past(reset), req_stall, "input taken during clearing pass")

endmodule

bind list_mode_event_histogram_filtered_top lmeh_checker u_lmeh_checker (
   .clock         (clock),
   .reset         (reset),
   .req_stall     (req_stall),
   .rsp_valid     (rsp_valid),
   .rsp_stall     (rsp_stall),
   .rsp_bin_count (rsp_bin_count),
   .rsp_status    (rsp_status),
   .rsp_halted    (rsp_halted)
);

[bench/histogram_checker.sv]
`timescale 1ns / 100ps

// watches both channels, predicts each result and compares it with the block
module histogram_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_stall,
   input  logic [1:0]  req_mode,
   input  logic [15:0] req_channel,
   input  logic [7:0]  req_pos_x,
   input  logic [7:0]  req_pos_y,
   input  logic [3:0]  req_read_x,
   input  logic [3:0]  req_read_y,
   input  logic [9:0]  req_read_channel,
   input  logic        rsp_valid,
   input  logic        rsp_stall,
   input  logic [31:0] rsp_bin_count,
   input  logic [2:0]  rsp_status,
   input  logic        rsp_halted,
   output int          mismatches,
   output int          outstanding
);

   typedef struct {
      logic [31:0] bin_count;
      logic [2:0]  status;
      logic        halted;
   } spectrum_result_type;

   // predicted bins, absent key means zero
   int unsigned         bin_counts[int];
   logic                stop_seen = 1'b0;
   spectrum_result_type expected_results[$];
   int                  mismatch_total = 0;

   function automatic int bin_addr(int x0, int y0, int stored_ch);
      return (x0 * lmeh_pkg::Y_SIZE + y0) * lmeh_pkg::CHANNELS + stored_ch;
   endfunction

   // apply one transaction to the predicted histogram and return its result
   function automatic spectrum_result_type histogram_step(
      logic [1:0] mode, logic [15:0] ch, logic [7:0] px, logic [7:0] py,
      logic [3:0] rx, logic [3:0] ry, logic [9:0] rc);
      spectrum_result_type res;
      int                  addr;
      int                  stored_ch;
      res.bin_count = '0;
      res.status    = lmeh_pkg::STAT_IGNORED;
      case (mode)
         lmeh_pkg::MODE_COUNT: begin
            if (stop_seen) begin
               res.status = lmeh_pkg::STAT_IGNORED;
            end else if (ch >= lmeh_pkg::CHANNELS) begin
               res.status = lmeh_pkg::STAT_BAD_CH;
            end else if (px == 0 || py == 0) begin
               res.status = lmeh_pkg::STAT_ZERO;
            end else if (px > lmeh_pkg::X_SIZE || py > lmeh_pkg::Y_SIZE) begin
               stop_seen  = 1'b1;
               res.status = lmeh_pkg::STAT_STOP_NOW;
            end else begin
               // channel halves are swapped before storing
               stored_ch = (ch >= lmeh_pkg::HALF_CH) ? int'(ch) - lmeh_pkg::HALF_CH
                                                     : int'(ch) + lmeh_pkg::HALF_CH;
               addr = bin_addr(int'(px) - 1, int'(py) - 1, stored_ch);
               if (bin_counts.exists(addr))
                  bin_counts[addr] = bin_counts[addr] + 1;
               else
                  bin_counts[addr] = 1;
               res.status = lmeh_pkg::STAT_COUNTED;
            end
         end
         lmeh_pkg::MODE_READ: begin
            res.status = lmeh_pkg::STAT_READ;
            if (rx < lmeh_pkg::X_SIZE && ry < lmeh_pkg::Y_SIZE && rc < lmeh_pkg::CHANNELS) begin
               addr = bin_addr(int'(rx), int'(ry), int'(rc));
               if (bin_counts.exists(addr))
                  res.bin_count = bin_counts[addr];
            end
         end
         lmeh_pkg::MODE_CLEAR: begin
            bin_counts.delete();
            stop_seen  = 1'b0;
            res.status = lmeh_pkg::STAT_CLEARED;
         end
         default: begin
            res.status = lmeh_pkg::STAT_IGNORED;
         end
      endcase
      res.halted = stop_seen;
      return res;
   endfunction

   task automatic report_mismatch(string what, spectrum_result_type exp_r);
      if (mismatch_total < 10)
         $display("%0t %s: expected count=%0d status=%0d halted=%0d, got count=%0d status=%0d halted=%0d",
                  $realtime, what, exp_r.bin_count, exp_r.status, exp_r.halted,
                  rsp_bin_count, rsp_status, rsp_halted);
      mismatch_total++;
   endtask

   // compare finished transactions first, then predict newly accepted ones
   always @(posedge clock) begin
      spectrum_result_type exp_r;
      if (reset) begin
         bin_counts.delete();
         stop_seen = 1'b0;
         expected_results.delete();
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_results.size() == 0) begin
               exp_r = '{bin_count: 'x, status: 'x, halted: 'x};
               report_mismatch("result with nothing pending", exp_r);
            end else begin
               exp_r = expected_results.pop_front();
               if (rsp_bin_count !== exp_r.bin_count || rsp_status !== exp_r.status ||
                   rsp_halted !== exp_r.halted)
                  report_mismatch("result mismatch", exp_r);
            end
         end
         if (req_valid && !req_stall)
            expected_results.push_back(histogram_step(req_mode, req_channel, req_pos_x,
               req_pos_y, req_read_x, req_read_y, req_read_channel));
      end
      mismatches  <= mismatch_total;
      outstanding <= expected_results.size();
   end

endmodule

[bench/testbench.sv]
`timescale 1ns / 100ps

module testbench;

   // mode value the block leaves unused
   localparam logic [1:0] MODE_UNUSED = 2'd3;

   localparam int RANDOM_ITEMS    = 1150;
   localparam int HOT_BINS        = 8;
   localparam int IDLE_PCT        = 37;
   localparam int QUIET_FIRST     = 600;
   localparam int QUIET_LAST      = 800;
   localparam int HOLD_AFTER      = 400;
   localparam int HOLD_OFF_CYCLES = 400;
   localparam int DRAIN_CYCLES    = 20;
   localparam int WATCHDOG_LIMIT  = 1000000;

   logic        clock = 1'b0;
   logic        reset;
   logic        req_valid;
   logic        req_stall;
   logic [1:0]  req_mode;
   logic [15:0] req_channel;
   logic [7:0]  req_pos_x;
   logic [7:0]  req_pos_y;
   logic [3:0]  req_read_x;
   logic [3:0]  req_read_y;
   logic [9:0]  req_read_channel;
   logic        rsp_valid;
   logic        rsp_stall;
   logic [31:0] rsp_bin_count;
   logic [2:0]  rsp_status;
   logic        rsp_halted;

   int mismatches;
   int outstanding;
   int items_sent    = 0;
   int results_taken = 0;
   int stuck_cycles  = 0;
   bit held_off      = 1'b0;

   typedef struct {
      logic [15:0] ch;
      logic [7:0]  px;
      logic [7:0]  py;
   } detector_event_type;

   // a few bins hit over and over so reads see counts above one
   detector_event_type hot_events[HOT_BINS];

   always #5 clock = ~clock;

   list_mode_event_histogram_filtered_top u_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_mode         (req_mode),
      .req_channel      (req_channel),
      .req_pos_x        (req_pos_x),
      .req_pos_y        (req_pos_y),
      .req_read_x       (req_read_x),
      .req_read_y       (req_read_y),
      .req_read_channel (req_read_channel),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_bin_count    (rsp_bin_count),
      .rsp_status       (rsp_status),
      .rsp_halted       (rsp_halted)
   );

   histogram_checker u_checker (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_mode         (req_mode),
      .req_channel      (req_channel),
      .req_pos_x        (req_pos_x),
      .req_pos_y        (req_pos_y),
      .req_read_x       (req_read_x),
      .req_read_y       (req_read_y),
      .req_read_channel (req_read_channel),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_bin_count    (rsp_bin_count),
      .rsp_status       (rsp_status),
      .rsp_halted       (rsp_halted),
      .mismatches       (mismatches),
      .outstanding      (outstanding)
   );

   // offer one transaction, after a random gap outside the quiet stretch, and wait until it is taken
   task automatic send_item(input logic [1:0] mode, input logic [15:0] ch,
                            input logic [7:0] px, input logic [7:0] py,
                            input logic [3:0] rx, input logic [3:0] ry,
                            input logic [9:0] rc);
      bit quiet;
      quiet = (items_sent >= QUIET_FIRST && items_sent < QUIET_LAST);
      while (!quiet && $urandom_range(99) < IDLE_PCT) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_mode         <= mode;
      req_channel      <= ch;
      req_pos_x        <= px;
      req_pos_y        <= py;
      req_read_x       <= rx;
      req_read_y       <= ry;
      req_read_channel <= rc;
      req_valid        <= 1'b1;
      do
         @(posedge clock);
      while (req_stall);
      items_sent++;
   endtask

   // mostly well-formed events and reads aimed at filled bins, plus noise
   task automatic random_item();
      int          pick;
      int          k;
      logic [1:0]  mode;
      logic [15:0] ch;
      logic [7:0]  px;
      logic [7:0]  py;
      logic [3:0]  rx;
      logic [3:0]  ry;
      logic [9:0]  rc;
      ch   = 16'($urandom);
      px   = 8'($urandom);
      py   = 8'($urandom);
      rx   = 4'($urandom);
      ry   = 4'($urandom);
      rc   = 10'($urandom);
      k    = $urandom_range(HOT_BINS - 1);
      pick = $urandom_range(99);
      if (pick < 30) begin
         mode = lmeh_pkg::MODE_COUNT;
         ch   = hot_events[k].ch;
         px   = hot_events[k].px;
         py   = hot_events[k].py;
      end else if (pick < 55) begin
         mode = lmeh_pkg::MODE_COUNT;
         ch   = 16'($urandom_range(lmeh_pkg::CHANNELS - 1));
         px   = 8'($urandom_range(lmeh_pkg::X_SIZE, 1));
         py   = 8'($urandom_range(lmeh_pkg::Y_SIZE, 1));
      end else if (pick < 67) begin
         // stored index has the channel halves swapped
         mode = lmeh_pkg::MODE_READ;
         rx   = 4'(hot_events[k].px - 8'd1);
         ry   = 4'(hot_events[k].py - 8'd1);
         rc   = 10'(hot_events[k].ch + 16'(lmeh_pkg::HALF_CH));
      end else if (pick < 77) begin
         mode = lmeh_pkg::MODE_READ;
      end else if (pick < 86) begin
         mode = lmeh_pkg::MODE_COUNT;
         ch   = 16'($urandom_range(16'hFFFF, lmeh_pkg::CHANNELS));
      end else if (pick < 95) begin
         mode = lmeh_pkg::MODE_COUNT;
         if ($urandom_range(1))
            px = '0;
         else
            py = '0;
      end else begin
         mode = MODE_UNUSED;
      end
      send_item(mode, ch, px, py, rx, ry, rc);
   endtask

   // receiver: random stalls, one long hold-off, and a quiet stretch
   initial begin
      rsp_stall <= 1'b0;
      forever begin
         @(posedge clock);
         if (rsp_valid && !rsp_stall)
            results_taken++;
         if (!held_off && results_taken >= HOLD_AFTER) begin
            held_off = 1'b1;
            rsp_stall <= 1'b1;
            repeat (HOLD_OFF_CYCLES) @(posedge clock);
         end else if (results_taken >= QUIET_FIRST && results_taken < QUIET_LAST) begin
            rsp_stall <= 1'b0;
         end else begin
            rsp_stall <= ($urandom_range(99) < IDLE_PCT);
         end
      end
   end

   // watchdog on cycles with no transaction on either channel
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         stuck_cycles <= 0;
      end else begin
         stuck_cycles <= stuck_cycles + 1;
         if (stuck_cycles >= WATCHDOG_LIMIT) begin
            $display("Test completed with failures");
            $finish;
         end
      end
   end

   // stimulus and verdict
   initial begin
      reset            <= 1'b1;
      req_valid        <= 1'b0;
      req_mode         <= lmeh_pkg::MODE_COUNT;
      req_channel      <= '0;
      req_pos_x        <= '0;
      req_pos_y        <= '0;
      req_read_x       <= '0;
      req_read_y       <= '0;
      req_read_channel <= '0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // directed: corners of the cube, check order, stop and clear
      send_item(lmeh_pkg::MODE_READ, 16'd0, 8'd0, 8'd0, 4'd0, 4'd0, 10'd0);
      send_item(lmeh_pkg::MODE_COUNT, 16'd0, 8'd1, 8'd1, 4'd0, 4'd0, 10'd0);
      send_item(lmeh_pkg::MODE_COUNT, 16'd0, 8'd1, 8'd1, 4'd0, 4'd0, 10'd0);
      send_item(lmeh_pkg::MODE_READ, 16'd0, 8'd0, 8'd0, 4'd0, 4'd0,
                10'(lmeh_pkg::HALF_CH));
      send_item(lmeh_pkg::MODE_COUNT, 16'(lmeh_pkg::CHANNELS - 1), 8'(lmeh_pkg::X_SIZE),
                8'(lmeh_pkg::Y_SIZE), 4'd0, 4'd0, 10'd0);
      send_item(lmeh_pkg::MODE_READ, 16'd0, 8'd0, 8'd0, 4'(lmeh_pkg::X_SIZE - 1),
                4'(lmeh_pkg::Y_SIZE - 1), 10'(lmeh_pkg::HALF_CH - 1));
      send_item(lmeh_pkg::MODE_COUNT, 16'(lmeh_pkg::HALF_CH - 1), 8'(lmeh_pkg::X_SIZE),
                8'd1, 4'd0, 4'd0, 10'd0);
      send_item(lmeh_pkg::MODE_READ, 16'd0, 8'd0, 8'd0, 4'(lmeh_pkg::X_SIZE - 1), 4'd0,
                10'(lmeh_pkg::CHANNELS - 1));
      send_item(lmeh_pkg::MODE_COUNT, 16'(lmeh_pkg::HALF_CH), 8'd1, 8'(lmeh_pkg::Y_SIZE),
                4'd0, 4'd0, 10'd0);
      send_item(lmeh_pkg::MODE_READ, 16'd0, 8'd0, 8'd0, 4'd0, 4'(lmeh_pkg::Y_SIZE - 1),
                10'd0);
      send_item(lmeh_pkg::MODE_COUNT, 16'(lmeh_pkg::CHANNELS), 8'd1, 8'd1, 4'd0, 4'd0,
                10'd0);
      send_item(lmeh_pkg::MODE_COUNT, 16'hFFFF, 8'd0, 8'hFF, 4'd0, 4'd0, 10'd0);
      send_item(lmeh_pkg::MODE_COUNT, 16'd5, 8'd0, 8'd3, 4'd0, 4'd0, 10'd0);
      send_item(lmeh_pkg::MODE_COUNT, 16'd5, 8'd3, 8'd0, 4'd0, 4'd0, 10'd0);
      send_item(lmeh_pkg::MODE_COUNT, 16'd7, 8'd0, 8'd200, 4'd0, 4'd0, 10'd0);
      send_item(lmeh_pkg::MODE_COUNT, 16'(lmeh_pkg::CHANNELS), 8'd200, 8'd1, 4'd0, 4'd0,
                10'd0);
      send_item(MODE_UNUSED, 16'hFFFF, 8'hFF, 8'hFF, 4'hF, 4'hF, 10'h3FF);
      send_item(lmeh_pkg::MODE_COUNT, 16'd0, 8'(lmeh_pkg::X_SIZE + 1), 8'd1, 4'd0, 4'd0,
                10'd0);
      send_item(lmeh_pkg::MODE_COUNT, 16'd0, 8'd1, 8'd1, 4'd0, 4'd0, 10'd0);
      send_item(lmeh_pkg::MODE_COUNT, 16'hFFFF, 8'hFF, 8'hFF, 4'd0, 4'd0, 10'd0);
      send_item(lmeh_pkg::MODE_READ, 16'd0, 8'd0, 8'd0, 4'd0, 4'd0,
                10'(lmeh_pkg::HALF_CH));
      send_item(MODE_UNUSED, 16'd0, 8'd0, 8'd0, 4'd0, 4'd0, 10'd0);
      send_item(lmeh_pkg::MODE_CLEAR, 16'hFFFF, 8'hFF, 8'hFF, 4'hF, 4'hF, 10'h3FF);
      send_item(lmeh_pkg::MODE_READ, 16'd0, 8'd0, 8'd0, 4'd0, 4'd0,
                10'(lmeh_pkg::HALF_CH));

      // random traffic over a small set of busy bins
      foreach (hot_events[i]) begin
         hot_events[i].ch = 16'($urandom_range(lmeh_pkg::CHANNELS - 1));
         hot_events[i].px = 8'($urandom_range(lmeh_pkg::X_SIZE, 1));
         hot_events[i].py = 8'($urandom_range(lmeh_pkg::Y_SIZE, 1));
      end
      repeat (RANDOM_ITEMS) random_item();

      // stop on a y beyond the cube, traffic while stopped, then clear and read back
      send_item(lmeh_pkg::MODE_COUNT, 16'($urandom_range(lmeh_pkg::CHANNELS - 1)),
                8'($urandom_range(lmeh_pkg::X_SIZE, 1)),
                8'($urandom_range(8'hFF, lmeh_pkg::Y_SIZE + 1)), 4'd0, 4'd0, 10'd0);
      repeat (10) random_item();
      send_item(lmeh_pkg::MODE_CLEAR, 16'($urandom), 8'($urandom), 8'($urandom),
                4'($urandom), 4'($urandom), 10'($urandom));
      foreach (hot_events[i])
         send_item(lmeh_pkg::MODE_READ, 16'd0, 8'd0, 8'd0, 4'(hot_events[i].px - 8'd1),
                   4'(hot_events[i].py - 8'd1),
                   10'(hot_events[i].ch + 16'(lmeh_pkg::HALF_CH)));
      req_valid <= 1'b0;

      // drain the pending results
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatches == 0 && outstanding == 0)
         $display("Test completed successfully");
      else
         $display("Test completed with failures");
      $finish;
   end

endmodule

[list_mode_event_histogram_filtered_top.f]
+incdir+hw/rtl
hw/rtl/lmeh_pkg.sv
hw/rtl/lmeh_ram.sv
hw/rtl/lmeh_datapath.sv
hw/rtl/lmeh_ctrl.sv
hw/rtl/list_mode_event_histogram_filtered_top.sv
hw/rtl/lmeh_checker.sv
bench/histogram_checker.sv
bench/testbench.sv
